FILE: rtl/core/caut_pkg.sv
// Shared types and constants of the cell automaton step unit.
`default_nettype none

package caut_pkg;

  localparam int RULE_BITS = 10;
  localparam int COUNT_W   = 4;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [APB_AW-1:0] ADDR_RULE_TABLE = 3'd0;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_GEN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL,
    ST_GEN_START,
    ST_GEN_RD,
    ST_GEN_LD,
    ST_GEN_CELL,
    ST_GEN_WR,
    ST_DONE
  } state_t;

  // Control of the row window and neighborhood unit.
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic first_col;
    logic last_col;
  } win_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/totalistic_cell_automaton_step_unit.sv
// Top level of the totalistic 3x3 cell automaton step unit.
// Flow: a write or read reads the addressed row and then loads the result register; the
// unused command goes straight to the result register. A generation clears the window, then
// per row does a memory read, a window load, a pass over each cell in the shared count and
// rule unit, and a row write-back. One item in flight; the next input transfer may share
// the result transfer's edge. Reset: synchronous; a clearing pass over all rows, input stalled.
`default_nettype none

module totalistic_cell_automaton_step_unit #(
  parameter int GRID_SIDE = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    command,
  input  wire logic [5:0]                    x_coord,
  input  wire logic [5:0]                    y_coord,
  input  wire logic                          cell_in,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               cell_out,
  output logic                               gen_done,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [caut_pkg::APB_AW-1:0]   paddr,
  input  wire logic [caut_pkg::APB_DW-1:0]   pwdata,
  output logic      [caut_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  import caut_pkg::*;

  localparam int CW     = $clog2(GRID_SIDE);        // row / column index width
  localparam int AW     = (CW > 6) ? CW : 6;        // coordinate compare width - 1
  localparam int RAM_AW = CW + 1;                   // bank bit plus row
  localparam int CENTRE = GRID_SIDE / 2;

  localparam logic [CW-1:0]        LAST_IDX   = CW'(GRID_SIDE - 1);
  localparam logic [CW-1:0]        CENTRE_IDX = CW'(CENTRE);
  localparam logic [GRID_SIDE-1:0] CENTRE_ROW = GRID_SIDE'(1) << CENTRE;
  localparam logic [AW:0]          SIDE_EXT   = (AW+1)'(GRID_SIDE);
  localparam logic [CW:0]          SIDE_LD    = (CW+1)'(GRID_SIDE);

  state_t state, state_next;

  // rule register
  logic [RULE_BITS-1:0] rule_table;

  // latched item
  cmd_t          cmd_r;
  logic [CW-1:0] x_r;
  logic [CW-1:0] y_r;
  logic          inside_r;
  logic          cell_in_r;

  // sequencer counters
  logic          bank;         // bank holding the live grid
  logic [CW-1:0] clr_row;
  logic [CW:0]   ld_row;       // next row to bring into the window (may reach GRID_SIDE)
  logic [CW-1:0] gen_row;      // row under evaluation
  logic [CW-1:0] col;

  // memory and window hookup
  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [GRID_SIDE-1:0] ram_wdata;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [GRID_SIDE-1:0] ram_rdata;
  logic [GRID_SIDE-1:0] cell_row;
  logic [GRID_SIDE-1:0] load_row;
  logic [GRID_SIDE-1:0] out_row;
  win_ctl_t             win_ctl;

  // result staging
  logic out_free;
  logic load_out;
  logic res_cell;
  logic res_gen;

  logic [AW:0] x_ext;
  logic [AW:0] y_ext;
  logic        in_inside;
  logic        cfg_write;

  // ---------------------------------------------------------------------------
  // Register port: pready is tied high, so every access completes without wait
  // states. Only the rule table is writable; other addresses read zero.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_RULE_TABLE);
  assign prdata    = (paddr == ADDR_RULE_TABLE) ? APB_DW'(rule_table) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_table <= '0;
    end else if (cfg_write) begin
      rule_table <= pwdata[RULE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Coordinates beyond the grid are legal on the port when GRID_SIDE < 64:
  // a write there is dropped and a read returns zero.
  // ---------------------------------------------------------------------------
  assign x_ext     = (AW+1)'(x_coord);
  assign y_ext     = (AW+1)'(y_coord);
  assign in_inside = (x_ext < SIDE_EXT) && (y_ext < SIDE_EXT);

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_r     <= cmd_t'(command);
      x_r       <= x_ext[CW-1:0];
      y_r       <= y_ext[CW-1:0];
      inside_r  <= in_inside;
      cell_in_r <= cell_in;
    end
  end

  // Row with the addressed cell replaced, for the read-modify-write of a write.
  always_comb begin
    cell_row       = ram_rdata;
    cell_row[x_r]  = cell_in_r;
  end

  // Rows past the bottom edge enter the window as zero.
  assign load_row = (ld_row < SIDE_LD) ? ram_rdata : '0;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    ram_we            = 1'b0;
    ram_waddr         = {bank, y_r};
    ram_wdata         = cell_row;
    ram_raddr         = {bank, y_r};
    win_ctl           = '0;
    win_ctl.first_col = (col == '0);
    win_ctl.last_col  = (col == LAST_IDX);
    load_out          = 1'b0;
    res_cell          = 1'b0;
    res_gen           = 1'b0;

    case (state)
      ST_CLEAR: begin
        // lay down the reset grid in bank zero, one row a cycle
        ram_we    = 1'b1;
        ram_waddr = {1'b0, clr_row};
        ram_wdata = (clr_row == CENTRE_IDX) ? CENTRE_ROW : '0;
        if (clr_row == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(command))
            CMD_WRITE, CMD_READ: state_next = ST_CELL_RD;
            CMD_GEN:             state_next = ST_GEN_START;
            default:             state_next = ST_DONE;
          endcase
        end
      end

      ST_CELL_RD: begin
        // read of the addressed row issued here, data next cycle
        state_next = ST_CELL;
      end

      ST_CELL: begin
        if (out_free) begin
          load_out = 1'b1;
          if (cmd_r == CMD_WRITE) begin
            res_cell = cell_in_r;
            ram_we   = inside_r;
          end else begin
            res_cell = inside_r & ram_rdata[x_r];
          end
          state_next = ST_IDLE;
        end
      end

      ST_GEN_START: begin
        win_ctl.clear = 1'b1;
        state_next    = ST_GEN_RD;
      end

      ST_GEN_RD: begin
        ram_raddr  = {bank, ld_row[CW-1:0]};
        state_next = ST_GEN_LD;
      end

      ST_GEN_LD: begin
        win_ctl.load = 1'b1;
        // the first row needs one more load before the window is full
        state_next = (ld_row == '0) ? ST_GEN_RD : ST_GEN_CELL;
      end

      ST_GEN_CELL: begin
        win_ctl.step = 1'b1;
        if (col == LAST_IDX) begin
          state_next = ST_GEN_WR;
        end
      end

      ST_GEN_WR: begin
        // new row goes to the other bank; the old grid stays intact for reading
        ram_we     = 1'b1;
        ram_waddr  = {~bank, gen_row};
        ram_wdata  = out_row;
        state_next = (gen_row == LAST_IDX) ? ST_DONE : ST_GEN_RD;
      end

      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_gen    = (cmd_r == CMD_GEN);
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank    <= 1'b0;
      clr_row <= '0;
      ld_row  <= '0;
      gen_row <= '0;
      col     <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (state == ST_GEN_START) begin
        ld_row  <= '0;
        gen_row <= '0;
      end
      if (state == ST_GEN_LD) begin
        ld_row <= ld_row + 1'b1;
      end
      if (state == ST_GEN_RD) begin
        col <= '0;
      end else if (state == ST_GEN_CELL) begin
        col <= col + 1'b1;
      end
      if (state == ST_GEN_WR) begin
        gen_row <= gen_row + 1'b1;
        // swap banks once the last row is written
        if (gen_row == LAST_IDX) begin
          bank <= ~bank;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the result until its transfer completes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cell_out <= res_cell;
      gen_done <= res_gen;
    end
  end

  caut_row_ram #(
    .ADDR_W (RAM_AW),
    .DATA_W (GRID_SIDE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  caut_window #(
    .GRID_SIDE (GRID_SIDE)
  ) u_window (
    .clk      (clk),
    .ctl      (win_ctl),
    .load_row (load_row),
    .rule     (rule_table),
    .out_row  (out_row)
  );

endmodule

`default_nettype wire

FILE: rtl/core/caut_row_ram.sv
// Row-wide grid memory, one write port and one registered read port.
`default_nettype none

module caut_row_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/caut_window.sv
// Three-row rotating window and the shared neighborhood count and rule lookup.
`default_nettype none

module caut_window #(
  parameter int GRID_SIDE = 64
) (
  input  wire logic                              clk,
  input  wire caut_pkg::win_ctl_t                ctl,
  input  wire logic [GRID_SIDE-1:0]              load_row,
  input  wire logic [caut_pkg::RULE_BITS-1:0]    rule,
  output logic      [GRID_SIDE-1:0]              out_row
);

  import caut_pkg::*;

  logic [GRID_SIDE-1:0] row_above;
  logic [GRID_SIDE-1:0] row_mid;
  logic [GRID_SIDE-1:0] row_below;
  logic [COUNT_W-1:0]   live;
  logic                 new_bit;

  // Bit 0 is the current column, bit 1 its right and the top bit its left neighbor.
  function automatic logic [COUNT_W-1:0] col_sum(input logic [GRID_SIDE-1:0] r,
                                                 input logic first, input logic last);
    logic [COUNT_W-1:0] s;
    s = COUNT_W'(r[0]);
    s = s + COUNT_W'(r[1] & ~last);
    s = s + COUNT_W'(r[GRID_SIDE-1] & ~first);
    return s;
  endfunction

  always_comb begin
    live = col_sum(row_above, ctl.first_col, ctl.last_col)
         + col_sum(row_mid,   ctl.first_col, ctl.last_col)
         + col_sum(row_below, ctl.first_col, ctl.last_col);
    new_bit = rule[live];
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      row_above <= '0;
      row_mid   <= '0;
      row_below <= '0;
    end else if (ctl.load) begin
      row_above <= row_mid;
      row_mid   <= row_below;
      row_below <= load_row;
    end else if (ctl.step) begin
      // rotate; after a full row every word is back in place
      row_above <= {row_above[0], row_above[GRID_SIDE-1:1]};
      row_mid   <= {row_mid[0],   row_mid[GRID_SIDE-1:1]};
      row_below <= {row_below[0], row_below[GRID_SIDE-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_row <= {new_bit, out_row[GRID_SIDE-1:1]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/caut_chk.sv
// Port-level checker for the cell automaton step unit, with its bind.
`default_nettype none

module caut_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic cell_out,
  input wire logic gen_done
);

  // reset starts the clearing pass, so input must be stalled right after it
  a_stall_after_rst: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // one item at a time: busy the cycle after an input transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // a generation result never carries a cell value
  a_gen_no_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && gen_done |-> !cell_out)
    else $error("generation result with cell_out set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_out) && $stable(gen_done))
    else $error("stalled result dropped or changed");

endmodule

bind totalistic_cell_automaton_step_unit caut_chk u_caut_chk (.*);

`default_nettype wire
